// File: rtl/trle_pkg.sv
// trle_pkg: types and constants shared by the tga run-length pixel decoder
// no dependencies
`timescale 1ns / 1ps

package trle_pkg;

  // decoder phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_COLOUR = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_PIXELS     = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_OVERRUN    = 2'd2;

  // header layout and packet decode
  localparam logic [2:0] HDR_LAST_BYTE = 3'd5;
  localparam logic [7:0] DEPTH_RGB     = 8'd24;
  localparam logic [7:0] DEPTH_RGBA    = 8'd32;
  localparam logic [7:0] RUN_FLAG      = 8'd128;
  localparam logic [7:0] RUN_BIAS      = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

  localparam int unsigned OUT_TDATA_W = 80;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] data_byte;
  } trle_item_t;

  typedef struct packed {
    logic        last_of_image;
    logic [1:0]  status;
    logic [31:0] pixel_index;
    logic [7:0]  repeat_count;
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } trle_result_t;

endpackage

// File: rtl/trle_in_reg.sv
// trle_in_reg: input register stage of the decoder
// depends on trle_pkg
`timescale 1ns / 1ps

module trle_in_reg
  import trle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  trle_item_t item_i,
  output logic       valid_o,
  input  logic       pop_i,
  output trle_item_t item_o
);

  logic       valid_q, valid_d;
  trle_item_t item_q;

  // takes a new transaction when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || pop_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/trle_core.sv
// trle_core: header, packet and colour-byte decode with the decoder state
// depends on trle_pkg
`timescale 1ns / 1ps

module trle_core
  import trle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  trle_item_t   item_i,
  output logic         res_valid_o,
  output trle_result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hbc_q, hbc_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        has_alpha_q, has_alpha_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [31:0] next_idx_q, next_idx_d;
  logic        is_run_q, is_run_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [1:0]  cbc_q, cbc_d;
  logic [23:0] colour_q, colour_d;

  // state as seen after a possible restart
  logic [2:0]  ph;
  logic [2:0]  hbc;
  logic [15:0] wid;
  logic [15:0] hgt;
  logic        has_a;
  logic [31:0] pl;
  logic [31:0] nidx;
  logic        run;
  logic [7:0]  ppl;
  logic [1:0]  cbc;
  logic [23:0] cb;

  logic [7:0]  b;
  logic [7:0]  depth;
  logic        hdr_ok;
  logic [31:0] area;
  logic [23:0] cb_new;
  logic [7:0]  alpha;
  logic        do_emit;
  logic [7:0]  rep;
  logic        overrun;
  logic [7:0]  clip;
  logic        last;
  logic        emit;
  trle_result_t res;

  assign b      = item_i.data_byte;
  assign depth  = cb[7:0];
  assign hdr_ok = (wid != 16'd0) && (hgt != 16'd0) &&
                  ((depth == DEPTH_RGB) || (depth == DEPTH_RGBA));
  assign area   = 32'(wid) * 32'(hgt);

  always_comb begin
    ph    = phase_q;
    hbc   = hbc_q;
    wid   = width_q;
    hgt   = height_q;
    has_a = has_alpha_q;
    pl    = pix_left_q;
    nidx  = next_idx_q;
    run   = is_run_q;
    ppl   = pkt_left_q;
    cbc   = cbc_q;
    cb    = colour_q;
    if (item_i.start_of_image) begin
      ph    = PH_HEADER;
      hbc   = '0;
      wid   = '0;
      hgt   = '0;
      has_a = 1'b0;
      pl    = '0;
      nidx  = '0;
      run   = 1'b0;
      ppl   = '0;
      cbc   = '0;
      cb    = '0;
    end

    phase_d     = ph;
    hbc_d       = hbc;
    width_d     = wid;
    height_d    = hgt;
    has_alpha_d = has_a;
    pix_left_d  = pl;
    next_idx_d  = nidx;
    is_run_d    = run;
    pkt_left_d  = ppl;
    cbc_d       = cbc;
    colour_d    = cb;

    res     = '0;
    emit    = 1'b0;
    cb_new  = cb;
    alpha   = ALPHA_OPAQUE;
    do_emit = 1'b0;
    rep     = 8'd1;
    overrun = 1'b0;
    clip    = 8'd0;
    last    = 1'b0;

    case (ph)
      PH_HEADER: begin
        case (hbc)
          3'd0: width_d  = {8'd0, b};
          3'd1: width_d  = {b, wid[7:0]};
          3'd2: height_d = {8'd0, b};
          3'd3: height_d = {b, hgt[7:0]};
          3'd4: colour_d = {16'd0, b};
          default: ;
        endcase
        if (hbc < HDR_LAST_BYTE) begin
          hbc_d = 3'(hbc + 3'd1);
        end else begin
          colour_d = '0;
          if (!hdr_ok) begin
            phase_d            = PH_DONE;
            emit               = 1'b1;
            res.status         = ST_BAD_HEADER;
            res.last_of_image  = 1'b1;
          end else begin
            has_alpha_d = (depth == DEPTH_RGBA);
            pix_left_d  = area;
            next_idx_d  = '0;
            phase_d     = PH_PACKET;
          end
        end
      end
      PH_PACKET: begin
        if (b < RUN_FLAG) begin
          is_run_d   = 1'b0;
          pkt_left_d = 8'(b + 8'd1);
        end else begin
          is_run_d   = 1'b1;
          pkt_left_d = 8'(b - RUN_BIAS);
        end
        cbc_d    = '0;
        colour_d = '0;
        phase_d  = PH_COLOUR;
      end
      PH_COLOUR: begin
        if (cbc != 2'd3) begin
          case (cbc)
            2'd0:    cb_new[7:0]   = cb[7:0] | b;
            2'd1:    cb_new[15:8]  = cb[15:8] | b;
            default: cb_new[23:16] = cb[23:16] | b;
          endcase
          cbc_d    = 2'(cbc + 2'd1);
          colour_d = cb_new;
          do_emit  = (cbc == 2'd2) && !has_a;
        end else begin
          alpha   = b;
          do_emit = 1'b1;
        end
        if (do_emit) begin
          rep     = run ? ppl : 8'd1;
          overrun = {24'd0, ppl} > pl;
          clip    = ({24'd0, rep} < pl) ? rep : pl[7:0];
          last    = overrun || ({24'd0, clip} == pl);

          emit              = 1'b1;
          res.red           = cb_new[23:16];
          res.green         = cb_new[15:8];
          res.blue          = cb_new[7:0];
          res.alpha         = alpha;
          res.repeat_count  = clip;
          res.pixel_index   = nidx;
          res.status        = overrun ? ST_OVERRUN : ST_PIXELS;
          res.last_of_image = last;

          next_idx_d = nidx + {24'd0, clip};
          pix_left_d = pl - {24'd0, clip};
          pkt_left_d = 8'(ppl - rep);
          cbc_d      = '0;
          colour_d   = '0;
          if (last) begin
            phase_d = PH_DONE;
          end else if (pkt_left_d == 8'd0) begin
            phase_d = PH_PACKET;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hbc_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      has_alpha_q <= 1'b0;
      pix_left_q  <= '0;
      next_idx_q  <= '0;
      is_run_q    <= 1'b0;
      pkt_left_q  <= '0;
      cbc_q       <= '0;
      colour_q    <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      hbc_q       <= hbc_d;
      width_q     <= width_d;
      height_q    <= height_d;
      has_alpha_q <= has_alpha_d;
      pix_left_q  <= pix_left_d;
      next_idx_q  <= next_idx_d;
      is_run_q    <= is_run_d;
      pkt_left_q  <= pkt_left_d;
      cbc_q       <= cbc_d;
      colour_q    <= colour_d;
    end
  end

  assign res_valid_o = fire_i && emit;
  assign res_o       = res;

endmodule

// File: rtl/trle_out_buf.sv
// trle_out_buf: two-entry result register that decouples the decoder from the sink
// depends on trle_pkg
`timescale 1ns / 1ps

module trle_out_buf
  import trle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  trle_result_t res_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_i,
  output trle_result_t res_o
);

  trle_result_t ent_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = ent_q[rd_ptr_q];
  assign do_pop  = valid_o && pop_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = 2'(cnt_q + {1'b0, push_i} - {1'b0, do_pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// File: rtl/tga_rle_pixel_decoder_top.sv
// a result passes through the input register and the result buffer before it is shown on the master side
// throughput: one byte per cycle while the result buffer has room; the only loop is the decode state update
// a two-entry result buffer keeps the input flowing while a result waits for tready
// reset: asynchronous, active low; decoder returns to idle and waits for start_of_image
// top level of the tga run-length pixel decoder
// depends on trle_pkg, trle_in_reg, trle_core, trle_out_buf
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top
  import trle_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]             s_axis_tuser,  // [0] start_of_image
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count,
  // [71:40] pixel_index, [73:72] status, [79:74] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast   // last_of_image
);

  trle_item_t   in_item;
  trle_item_t   reg_item;
  logic         reg_valid;
  logic         obuf_ready;
  logic         fire;
  logic         res_valid;
  trle_result_t res;
  trle_result_t out_res;

  assign in_item.data_byte      = s_axis_tdata;
  assign in_item.start_of_image = s_axis_tuser[0];

  // decode one held byte per cycle while the result buffer has room
  assign fire = reg_valid && obuf_ready;

  trle_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .pop_i   (fire),
    .item_o  (reg_item)
  );

  trle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (reg_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  trle_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .ready_o (obuf_ready),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.status, out_res.pixel_index, out_res.repeat_count,
                         out_res.alpha, out_res.blue, out_res.green, out_res.red};
  assign m_axis_tlast = out_res.last_of_image;

endmodule

// File: rtl/trle_checker.sv
// trle_checker: port-level assertions for the tga run-length pixel decoder
// depends on trle_pkg; bound to tga_rle_pixel_decoder_top
`timescale 1ns / 1ps

module trle_checker
  import trle_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  logic [1:0]  st;
  logic [7:0]  rep;
  logic [31:0] idx;

  assign st  = m_axis_tdata[73:72];
  assign rep = m_axis_tdata[39:32];
  assign idx = m_axis_tdata[71:40];

  // a stalled transaction stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // errors always end the image
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_BAD_HEADER || st == ST_OVERRUN) |-> m_axis_tlast)
    else $error("error result without last_of_image");

  // header errors carry no pixels
  a_bad_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_BAD_HEADER |-> rep == 8'd0 && idx == 32'd0)
    else $error("header error carries pixel data");

  // a pixel result always covers at least one pixel
  a_pix_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_PIXELS || st == ST_OVERRUN) |-> rep != 8'd0 && rep <= 8'd128)
    else $error("pixel result with bad repeat count");

  // no undefined status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> st != 2'd3)
    else $error("undefined status code");

endmodule

bind tga_rle_pixel_decoder_top trle_checker u_trle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb.sv
// tb: self-checking bench for tga_rle_pixel_decoder_top, predicts every result
// in order and compares each master-side transaction against it; random idles both sides
// depends on trle_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;
  import trle_pkg::*;

  localparam int unsigned TOTAL_BYTES = 1350;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 8;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  tga_rle_pixel_decoder_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state as the bench tracks it
  logic [2:0]  dec_phase;
  logic [2:0]  dec_hdr_cnt;
  logic [15:0] dec_width;
  logic [15:0] dec_height;
  logic [7:0]  dec_depth;
  logic        dec_alpha;
  logic [31:0] dec_pix_left;
  logic [31:0] dec_next_idx;
  logic        dec_run;
  logic [7:0]  dec_pkt_left;
  logic [1:0]  dec_col_cnt;
  logic [23:0] dec_colour;

  trle_result_t pixels_due[$];

  int unsigned bytes_sent;
  int unsigned n_errors;
  int unsigned n_images;
  int unsigned n_pixel_results;
  int unsigned n_bad_headers;
  int unsigned n_overruns;
  int unsigned n_checked;
  int unsigned quiet_cycles;
  bit          steady;

  task automatic clear_decoder();
    dec_phase    = PH_IDLE;
    dec_hdr_cnt  = '0;
    dec_width    = '0;
    dec_height   = '0;
    dec_depth    = '0;
    dec_alpha    = 1'b0;
    dec_pix_left = '0;
    dec_next_idx = '0;
    dec_run      = 1'b0;
    dec_pkt_left = '0;
    dec_col_cnt  = '0;
    dec_colour   = '0;
  endtask

  // advance the tracked decoder by one accepted byte, queue the result it causes
  task automatic decode_byte(input logic [7:0] b, input logic sof);
    trle_result_t r;
    logic         emit;
    logic         done_px;
    logic         ovr;
    logic [7:0]   a;
    logic [31:0]  rep;
    logic [31:0]  clip;
    emit = 1'b0;
    r    = '0;
    if (sof) begin
      clear_decoder();
      dec_phase = PH_HEADER;
    end
    case (dec_phase)
      PH_HEADER: begin
        case (dec_hdr_cnt)
          3'd0: dec_width[7:0] = b;
          3'd1: dec_width[15:8] = b;
          3'd2: dec_height[7:0] = b;
          3'd3: dec_height[15:8] = b;
          3'd4: dec_depth = b;
          default: ;
        endcase
        if (dec_hdr_cnt < HDR_LAST_BYTE) begin
          dec_hdr_cnt++;
        end else if (dec_width == 0 || dec_height == 0 ||
                     (dec_depth != DEPTH_RGB && dec_depth != DEPTH_RGBA)) begin
          dec_phase       = PH_DONE;
          r.status        = ST_BAD_HEADER;
          r.last_of_image = 1'b1;
          emit            = 1'b1;
          n_bad_headers++;
        end else begin
          dec_alpha    = (dec_depth == DEPTH_RGBA);
          dec_pix_left = 32'(dec_width) * 32'(dec_height);
          dec_next_idx = '0;
          dec_phase    = PH_PACKET;
        end
      end
      PH_PACKET: begin
        if (b < RUN_FLAG) begin
          dec_run      = 1'b0;
          dec_pkt_left = b + 8'd1;
        end else begin
          dec_run      = 1'b1;
          dec_pkt_left = b - RUN_BIAS;
        end
        dec_col_cnt = '0;
        dec_colour  = '0;
        dec_phase   = PH_COLOUR;
      end
      PH_COLOUR: begin
        a = ALPHA_OPAQUE;
        if (dec_col_cnt < 2'd3) begin
          dec_colour[dec_col_cnt*8 +: 8] = b;
          dec_col_cnt++;
          done_px = (dec_col_cnt == 2'd3) && !dec_alpha;
        end else begin
          a       = b;
          done_px = 1'b1;
        end
        if (done_px) begin
          rep  = dec_run ? 32'(dec_pkt_left) : 32'd1;
          ovr  = 32'(dec_pkt_left) > dec_pix_left;
          clip = (rep < dec_pix_left) ? rep : dec_pix_left;
          r.red           = dec_colour[23:16];
          r.green         = dec_colour[15:8];
          r.blue          = dec_colour[7:0];
          r.alpha         = a;
          r.repeat_count  = clip[7:0];
          r.pixel_index   = dec_next_idx;
          r.status        = ovr ? ST_OVERRUN : ST_PIXELS;
          r.last_of_image = ovr || (clip == dec_pix_left);
          emit            = 1'b1;
          if (ovr) n_overruns++;
          n_pixel_results++;
          dec_next_idx += clip;
          dec_pix_left -= clip;
          dec_pkt_left -= rep[7:0];
          dec_col_cnt  = '0;
          dec_colour   = '0;
          if (r.last_of_image) dec_phase = PH_DONE;
          else if (dec_pkt_left == 0) dec_phase = PH_PACKET;
        end
      end
      default: ;
    endcase
    if (emit) pixels_due.push_back(r);
  endtask

  // one input transaction, sometimes with a random idle gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (!steady && $urandom_range(0, 99) < 22) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] depth);
    n_images++;
    send_byte(w[7:0], 1'b1);
    send_byte(w[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(depth, 1'b0);
    send_byte(8'($urandom), 1'b0);
  endtask

  // stream order is blue, green, red, then alpha at 32 bpp
  task automatic send_colour(input logic [31:0] rgba, input logic with_alpha);
    send_byte(rgba[23:16], 1'b0);
    send_byte(rgba[15:8], 1'b0);
    send_byte(rgba[7:0], 1'b0);
    if (with_alpha) send_byte(rgba[31:24], 1'b0);
  endtask

  function automatic string show(input trle_result_t r);
    return $sformatf("r=%h g=%h b=%h a=%h rep=%0d idx=%0d st=%0d last=%b", r.red, r.green,
                     r.blue, r.alpha, r.repeat_count, r.pixel_index, r.status,
                     r.last_of_image);
  endfunction

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    trle_result_t got;
    trle_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = trle_result_t'({m_axis_tlast, m_axis_tdata[73:0]});
      if (pixels_due.size() == 0) begin
        report_error($sformatf("unexpected result %s", show(got)));
      end else begin
        want = pixels_due.pop_front();
        n_checked++;
        if (got !== want)
          report_error($sformatf("expected %s, got %s", show(want), show(got)));
      end
    end
  end

  // cycles in which neither side moves a transaction
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout, %0d results still outstanding", $time, pixels_due.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_ignored_bytes();
    // idle after reset: nothing comes out
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_bad_headers();
    send_header(16'd0, 16'd3, DEPTH_RGB);
    send_byte(8'ha5, 1'b0);  // finished, ignored
    send_header(16'd2, 16'd2, 8'd25);
  endtask

  task automatic test_extreme_image();
    // largest dimensions, one raw pixel, then a run of 128 that leaves the image unfinished
    send_header(16'hffff, 16'hffff, DEPTH_RGBA);
    send_byte(8'h00, 1'b0);
    send_colour(32'hffff_ffff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_colour(32'h0000_0000, 1'b1);
  endtask

  task automatic test_overruns();
    // raw packet of 128 pixels into a 1x1 image
    send_header(16'd1, 16'd1, DEPTH_RGB);
    send_byte(8'h7f, 1'b0);
    send_colour(32'h0012_3456, 1'b0);
    send_byte(8'h5a, 1'b0);
    // run of 6 into a 2x1 image is clipped to 2
    send_header(16'd2, 16'd1, DEPTH_RGB);
    send_byte(8'h85, 1'b0);
    send_colour(32'h00ab_cdef, 1'b0);
  endtask

  task automatic test_exact_end();
    send_header(16'd3, 16'd1, DEPTH_RGB);
    send_byte(RUN_FLAG, 1'b0);
    send_colour(32'h0001_0203, 1'b0);
    send_byte(8'h01, 1'b0);
    send_colour(32'h0080_7f40, 1'b0);
    send_colour(32'h00c0_e0f0, 1'b0);
    wait_drained();
  endtask

  task automatic random_packet(output bit cut);
    logic [7:0] n;
    cut = 1'b0;
    n = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 127));
    send_byte($urandom_range(0, 1) ? (RUN_FLAG | n) : n, 1'b0);
    while (dec_phase == PH_COLOUR && !cut) begin
      if ($urandom_range(0, 299) == 0) cut = 1'b1;
      else send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic test_random_streams();
    int unsigned pick;
    int unsigned budget;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  d;
    bit          cut;
    while (bytes_sent < TOTAL_BYTES) begin
      steady = (bytes_sent >= 500 && bytes_sent < 800);
      pick   = $urandom_range(0, 99);
      if (pick < 8) begin
        w = 16'($urandom_range(1, 65535));
        h = 16'($urandom_range(1, 65535));
        d = $urandom_range(0, 1) ? DEPTH_RGB : DEPTH_RGBA;
        case ($urandom_range(0, 3))
          0: w = '0;
          1: h = '0;
          2: begin
            d = 8'($urandom);
            if (d == DEPTH_RGB || d == DEPTH_RGBA) d = d + 8'd1;
          end
          default: ;
        endcase
        if (pick < 2) begin
          // header cut short by the next start
          n_images++;
          send_byte(w[7:0], 1'b1);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
        end else begin
          send_header(w, h, d);
        end
      end else begin
        if (pick < 14) begin
          w      = 16'($urandom_range(1, 65535));
          h      = 16'($urandom_range(1, 65535));
          budget = $urandom_range(2, 6);
        end else begin
          w      = 16'($urandom_range(1, 6));
          h      = 16'($urandom_range(1, 6));
          budget = 1000;
        end
        send_header(w, h, $urandom_range(0, 1) ? DEPTH_RGB : DEPTH_RGBA);
        cut = 1'b0;
        while (dec_phase == PH_PACKET && !cut && budget != 0) begin
          random_packet(cut);
          budget--;
          if ($urandom_range(0, 99) < 2) cut = 1'b1;
        end
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
      if (n_images % 15 == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_decoder();
    bytes_sent      = 0;
    n_errors        = 0;
    n_images        = 0;
    n_pixel_results = 0;
    n_bad_headers   = 0;
    n_overruns      = 0;
    n_checked       = 0;
    quiet_cycles    = 0;
    steady          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_ignored_bytes();
    test_bad_headers();
    test_extreme_image();
    test_overruns();
    test_exact_end();
    test_random_streams();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixels_due.size() != 0)
      report_error($sformatf("%0d results never arrived", pixels_due.size()));
    $display("covered %0d bytes over %0d images: %0d pixel results, %0d overruns,",
             bytes_sent, n_images, n_pixel_results, n_overruns);
    $display("%0d rejected headers; %0d transactions checked, %0d mismatches",
             n_bad_headers, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
